// ===== hdl/tsa_pkg.sv =====
// tsa_pkg: types and constants shared by the timer slot allocator
// no dependencies; used by tsa_ctrl, tsa_dpath and the top level
`timescale 1ns / 1ps
package tsa_pkg;

  // table geometry
  localparam int SLOTS  = 256;
  localparam int SLOT_W = 8;
  localparam int HEAPS  = 32;
  localparam int HEAP_W = 5;

  // field widths
  localparam int CMD_W    = 2;
  localparam int OWNER_W  = 16;
  localparam int TICKET_W = 9;
  localparam int CODE_W   = 13;
  localparam int DELAY_W  = 32;
  localparam int STATUS_W = 3;
  localparam int LEFT_W   = 4;
  localparam int CFG_W    = 5;

  // packed stream widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_FIRE   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NOT_ACTIVE = 3'd2,
    ST_NOT_INIT   = 3'd3,
    ST_NOT_OWNER  = 3'd4,
    ST_NOT_ACKED  = 3'd5,
    ST_FIRE_EMPTY = 3'd6,
    ST_WRONG_HEAP = 3'd7
  } status_t;

  typedef enum logic {
    CFG_HEAP_INDEX  = 1'b0,
    CFG_REUSE_DELAY = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_LOOK,
    FSM_CHECK,
    FSM_DONE
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan_en;
    logic look_en;
    logic check_en;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } dpath_sts_t;

endpackage

// ===== hdl/timer_slot_allocator_with_reuse_delay_unit.sv =====
// Timer slot allocator with reuse delay.
// Input stream: one request per transaction, command in in_tuser. Allocate
// scans the 256 slots from slot 0 one per cycle; cancel and fire look up a
// single slot. Every request yields exactly one result transaction.
// Allocate runs the scan pipeline through the countdown memory read port.
// One request is in work at a time: a new request is accepted only once
// the result of the last one has been loaded into the output register.
// Configuration port: cfg_index 0 heap index, 1 reuse delay; always ready.
// The user must write it only while idle; the unit does not enforce it.
// Reset (rst_n low, synchronous): all slots empty with zero countdown,
// heap index 0, reuse delay 2; no result pending. No clearing pass needed.
// When the result receiver stalls, the result stays in the output register;
// a following request is still accepted and worked on, and its result waits
// until the output register is taken.
// depends on tsa_pkg, tsa_ctrl, tsa_dpath, tsa_ram
`timescale 1ns / 1ps
module timer_slot_allocator_with_reuse_delay_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // owner_tag[15:0], ticket[24:16], alarm_code[37:25], delay_ms[69:38],
  // cancel_ack[70], zero[71]
  input  logic [tsa_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd[1:0]
  input  logic [tsa_pkg::CMD_W-1:0]         in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // ticket_out[8:0], alarm_code_out[21:9], delay_out[53:22], owner_out[69:54],
  // notify[70], zero[71]
  output logic [tsa_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[2:0]
  output logic [tsa_pkg::STATUS_W-1:0]      out_tuser,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [tsa_pkg::CFG_W-1:0]         cfg_data
);

  tsa_pkg::ctrl_cmd_t  cmd;
  tsa_pkg::dpath_sts_t sts;

  logic [tsa_pkg::TICKET_W-1:0] ticket_out;
  logic [tsa_pkg::CODE_W-1:0]   alarm_code_out;
  logic [tsa_pkg::DELAY_W-1:0]  delay_out;
  logic [tsa_pkg::OWNER_W-1:0]  owner_out;
  logic                         notify;

  assign cfg_ready = 1'b1;

  // sequencing
  tsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // slot table and result path
  tsa_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_tuser),
    .in_owner_tag       (in_tdata[15:0]),
    .in_ticket          (in_tdata[24:16]),
    .in_alarm_code      (in_tdata[37:25]),
    .in_delay_ms        (in_tdata[69:38]),
    .in_cancel_ack      (in_tdata[70]),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (out_tuser),
    .out_ticket_out     (ticket_out),
    .out_alarm_code_out (alarm_code_out),
    .out_delay_out      (delay_out),
    .out_owner_out      (owner_out),
    .out_notify         (notify)
  );

  // result packing, lowest field first
  assign out_tdata = {1'b0, notify, owner_out, delay_out, alarm_code_out, ticket_out};

endmodule

// ===== hdl/tsa_ram.sv =====
// tsa_ram: generic single write, single read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
module tsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tsa_ctrl.sv =====
// tsa_ctrl: sequencing state machine of the timer slot allocator
// depends on tsa_pkg
`timescale 1ns / 1ps
module tsa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [tsa_pkg::CMD_W-1:0]   in_cmd,
  output logic                        in_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  output tsa_pkg::ctrl_cmd_t          cmd,
  input  tsa_pkg::dpath_sts_t         sts
);

  tsa_pkg::fsm_t state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || out_ready;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsa_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tsa_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_cmd == tsa_pkg::CMD_ALLOC) begin
            state_nxt = tsa_pkg::FSM_SCAN;
          end else begin
            state_nxt = tsa_pkg::FSM_LOOK;
          end
        end
      end
      tsa_pkg::FSM_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = tsa_pkg::FSM_DONE;
        end
      end
      tsa_pkg::FSM_LOOK: begin
        cmd.look_en = 1'b1;
        state_nxt   = tsa_pkg::FSM_CHECK;
      end
      tsa_pkg::FSM_CHECK: begin
        cmd.check_en = 1'b1;
        state_nxt    = tsa_pkg::FSM_DONE;
      end
      tsa_pkg::FSM_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = tsa_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = tsa_pkg::FSM_IDLE;
      end
    endcase
  end

  // result transaction handshake
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/tsa_dpath.sv =====
// tsa_dpath: slot table, scan pipeline, command checks and result registers
// depends on tsa_pkg and tsa_ram
`timescale 1ns / 1ps
module tsa_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  // captured request
  input  logic [tsa_pkg::CMD_W-1:0]      in_cmd,
  input  logic [tsa_pkg::OWNER_W-1:0]    in_owner_tag,
  input  logic [tsa_pkg::TICKET_W-1:0]   in_ticket,
  input  logic [tsa_pkg::CODE_W-1:0]     in_alarm_code,
  input  logic [tsa_pkg::DELAY_W-1:0]    in_delay_ms,
  input  logic                           in_cancel_ack,
  // configuration writes
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [tsa_pkg::CFG_W-1:0]      cfg_data,
  // control
  input  tsa_pkg::ctrl_cmd_t             cmd,
  output tsa_pkg::dpath_sts_t            sts,
  // result
  output logic [tsa_pkg::STATUS_W-1:0]   out_status,
  output logic [tsa_pkg::TICKET_W-1:0]   out_ticket_out,
  output logic [tsa_pkg::CODE_W-1:0]     out_alarm_code_out,
  output logic [tsa_pkg::DELAY_W-1:0]    out_delay_out,
  output logic [tsa_pkg::OWNER_W-1:0]    out_owner_out,
  output logic                           out_notify
);

  localparam int SW = tsa_pkg::SLOT_W;
  // slot entry: busy mark above the reuse countdown
  localparam int EW = tsa_pkg::LEFT_W + 1;

  // configuration registers
  logic [tsa_pkg::HEAP_W-1:0] heap_index_r;
  logic [tsa_pkg::LEFT_W-1:0] reuse_delay_r;

  // request registers
  logic [tsa_pkg::CMD_W-1:0]    cmd_r;
  logic [tsa_pkg::OWNER_W-1:0]  owner_r;
  logic [tsa_pkg::TICKET_W-1:0] ticket_r;
  logic [tsa_pkg::CODE_W-1:0]   code_r;
  logic [tsa_pkg::DELAY_W-1:0]  delay_r;
  logic                         ack_r;

  // entry valid flags, an unwritten entry reads as empty with zero countdown
  logic [tsa_pkg::SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic                      vld_q_r;

  // scan pipeline
  logic [SW:0]   rd_idx_r;
  logic [SW-1:0] chk_idx_r;
  logic          chk_vld_r;
  logic [SW-1:0] look_slot_r;

  // result staging
  logic [tsa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [tsa_pkg::TICKET_W-1:0] res_ticket_r, res_ticket_nxt;
  logic [tsa_pkg::CODE_W-1:0]   res_code_r, res_code_nxt;
  logic [tsa_pkg::DELAY_W-1:0]  res_delay_r, res_delay_nxt;
  logic [tsa_pkg::OWNER_W-1:0]  res_owner_r, res_owner_nxt;
  logic                         res_notify_r, res_notify_nxt;

  // output registers
  logic [tsa_pkg::STATUS_W-1:0] out_status_r;
  logic [tsa_pkg::TICKET_W-1:0] out_ticket_r;
  logic [tsa_pkg::CODE_W-1:0]   out_code_r;
  logic [tsa_pkg::DELAY_W-1:0]  out_delay_r;
  logic [tsa_pkg::OWNER_W-1:0]  out_owner_r;
  logic                         out_notify_r;

  // ram ports
  logic                         slot_we;
  logic [SW-1:0]                slot_waddr;
  logic [EW-1:0]                slot_wdata;
  logic [SW-1:0]                slot_raddr;
  logic [EW-1:0]                slot_q;
  logic                         owner_we;
  logic [tsa_pkg::OWNER_W-1:0]  owner_q;

  // decoded request
  logic [tsa_pkg::TICKET_W-1:0] ticket_m1;
  logic [SW-1:0]                look_slot;
  logic [tsa_pkg::HEAP_W-1:0]   code_heap;
  logic                         eval;
  logic [EW-1:0]                slot_cur;
  logic                         busy_cur;
  logic                         slot_free;
  logic [tsa_pkg::LEFT_W-1:0]   left_cur;
  logic                         hit;

  assign ticket_m1 = ticket_r - tsa_pkg::TICKET_W'(1);
  assign code_heap = code_r[tsa_pkg::CODE_W-1:SW];
  assign look_slot = (cmd_r == tsa_pkg::CMD_CANCEL) ? ticket_m1[SW-1:0] : code_r[SW-1:0];

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_index_r  <= '0;
      reuse_delay_r <= tsa_pkg::LEFT_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        tsa_pkg::CFG_HEAP_INDEX:  heap_index_r  <= cfg_data[tsa_pkg::HEAP_W-1:0];
        tsa_pkg::CFG_REUSE_DELAY: reuse_delay_r <= cfg_data[tsa_pkg::LEFT_W-1:0];
        default: ;
      endcase
    end
  end

  // capture request on acceptance
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r    <= in_cmd;
      owner_r  <= in_owner_tag;
      ticket_r <= in_ticket;
      code_r   <= in_alarm_code;
      delay_r  <= in_delay_ms;
      ack_r    <= in_cancel_ack;
    end
    if (cmd.look_en) begin
      look_slot_r <= look_slot;
    end
  end

  // scan pipeline: read one slot per cycle, evaluate it the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.start) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.scan_en) begin
      rd_idx_r  <= rd_idx_r + (SW+1)'(1);
      chk_vld_r <= !rd_idx_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      chk_idx_r <= rd_idx_r[SW-1:0];
    end
  end

  // slot entry read: scan address while scanning, else the looked-up slot
  assign slot_raddr = cmd.scan_en ? rd_idx_r[SW-1:0] : look_slot;

  // valid flag read alongside the slot memory
  always_ff @(posedge clk) begin
    vld_q_r <= slot_vld_r[slot_raddr];
  end

  assign slot_cur  = vld_q_r ? slot_q : '0;
  assign busy_cur  = slot_cur[tsa_pkg::LEFT_W];
  assign left_cur  = slot_cur[tsa_pkg::LEFT_W-1:0];
  assign slot_free = !busy_cur;

  assign eval      = cmd.scan_en && chk_vld_r;
  assign hit       = eval && slot_free && (left_cur == '0);
  assign sts.scan_done = hit || (eval && (chk_idx_r == SW'(tsa_pkg::SLOTS - 1)));

  // slot state updates, result staging and ram writes
  always_comb begin
    slot_vld_nxt   = slot_vld_r;
    slot_we        = 1'b0;
    slot_waddr     = chk_idx_r;
    slot_wdata     = {1'b0, left_cur - tsa_pkg::LEFT_W'(1)};
    owner_we       = 1'b0;
    res_status_nxt = res_status_r;
    res_ticket_nxt = res_ticket_r;
    res_code_nxt   = res_code_r;
    res_delay_nxt  = res_delay_r;
    res_owner_nxt  = res_owner_r;
    res_notify_nxt = res_notify_r;

    if (eval) begin
      // allocation scan step
      if (hit) begin
        slot_we                 = 1'b1;
        slot_wdata              = {1'b1, tsa_pkg::LEFT_W'(0)};
        slot_vld_nxt[chk_idx_r] = 1'b1;
        owner_we       = 1'b1;
        res_status_nxt = tsa_pkg::ST_OK;
        res_ticket_nxt = {1'b0, chk_idx_r} + tsa_pkg::TICKET_W'(1);
        res_code_nxt   = {heap_index_r, chk_idx_r};
        res_delay_nxt  = delay_r;
        res_owner_nxt  = '0;
        res_notify_nxt = 1'b0;
      end else begin
        if (slot_free) begin
          slot_we = 1'b1;
        end
        res_status_nxt = tsa_pkg::ST_FULL;
        res_ticket_nxt = '0;
        res_code_nxt   = '0;
        res_delay_nxt  = '0;
        res_owner_nxt  = '0;
        res_notify_nxt = 1'b0;
      end
    end else if (cmd.check_en) begin
      // cancel and fire checks
      res_ticket_nxt = '0;
      res_code_nxt   = '0;
      res_delay_nxt  = '0;
      res_owner_nxt  = '0;
      res_notify_nxt = 1'b0;
      res_status_nxt = tsa_pkg::ST_NOT_ACTIVE;
      slot_waddr     = look_slot_r;
      slot_wdata     = {1'b0, reuse_delay_r};
      case (cmd_r)
        tsa_pkg::CMD_CANCEL: begin
          if (ticket_r > tsa_pkg::TICKET_W'(tsa_pkg::SLOTS)) begin
            res_status_nxt = tsa_pkg::ST_NOT_ACTIVE;
          end else if (ticket_r == '0) begin
            res_status_nxt = tsa_pkg::ST_NOT_INIT;
          end else if (!busy_cur) begin
            res_status_nxt = tsa_pkg::ST_NOT_ACTIVE;
          end else if (owner_q != owner_r) begin
            res_status_nxt = tsa_pkg::ST_NOT_OWNER;
          end else if (!ack_r) begin
            res_status_nxt = tsa_pkg::ST_NOT_ACKED;
          end else begin
            res_status_nxt            = tsa_pkg::ST_OK;
            slot_vld_nxt[look_slot_r] = 1'b1;
            slot_we                   = 1'b1;
          end
        end
        tsa_pkg::CMD_FIRE: begin
          if ((int'(code_heap) >= tsa_pkg::HEAPS) || (code_heap != heap_index_r)) begin
            res_status_nxt = tsa_pkg::ST_WRONG_HEAP;
          end else begin
            if (busy_cur) begin
              res_status_nxt = tsa_pkg::ST_OK;
              res_owner_nxt  = owner_q;
              res_notify_nxt = 1'b1;
            end else begin
              res_status_nxt = tsa_pkg::ST_FIRE_EMPTY;
            end
            slot_vld_nxt[look_slot_r] = 1'b1;
            slot_we                   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // entry valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else begin
      slot_vld_r <= slot_vld_nxt;
    end
  end

  // result staging registers
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_ticket_r <= res_ticket_nxt;
    res_code_r   <= res_code_nxt;
    res_delay_r  <= res_delay_nxt;
    res_owner_r  <= res_owner_nxt;
    res_notify_r <= res_notify_nxt;
  end

  // output registers, loaded when the result channel is free
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_ticket_r <= res_ticket_r;
      out_code_r   <= res_code_r;
      out_delay_r  <= res_delay_r;
      out_owner_r  <= res_owner_r;
      out_notify_r <= res_notify_r;
    end
  end

  assign out_status         = out_status_r;
  assign out_ticket_out     = out_ticket_r;
  assign out_alarm_code_out = out_code_r;
  assign out_delay_out      = out_delay_r;
  assign out_owner_out      = out_owner_r;
  assign out_notify         = out_notify_r;

  // busy marks and reuse countdowns; unwritten entries read as empty
  tsa_ram #(
    .WIDTH (EW),
    .DEPTH (tsa_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_q)
  );

  // owner tags, written on allocation
  tsa_ram #(
    .WIDTH (tsa_pkg::OWNER_W),
    .DEPTH (tsa_pkg::SLOTS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (owner_we),
    .waddr (chk_idx_r),
    .wdata (owner_r),
    .raddr (look_slot),
    .rdata (owner_q)
  );

endmodule

// ===== verif/timer_slot_allocator_with_reuse_delay_unit_tb.sv =====
// timer_slot_allocator_with_reuse_delay_unit_tb: self-checking bench for the timer slot
// allocator; predicts every result from its own slot table and compares field by field
// depends on tsa_pkg and timer_slot_allocator_with_reuse_delay_unit
`timescale 1ns / 1ps
module timer_slot_allocator_with_reuse_delay_unit_tb;

  localparam int CMD_W      = tsa_pkg::CMD_W;
  localparam int OWNER_W    = tsa_pkg::OWNER_W;
  localparam int TICKET_W   = tsa_pkg::TICKET_W;
  localparam int CODE_W     = tsa_pkg::CODE_W;
  localparam int DELAY_W    = tsa_pkg::DELAY_W;
  localparam int STATUS_W   = tsa_pkg::STATUS_W;
  localparam int LEFT_W     = tsa_pkg::LEFT_W;
  localparam int HEAP_W     = tsa_pkg::HEAP_W;
  localparam int SLOT_W     = tsa_pkg::SLOT_W;
  localparam int SLOTS      = tsa_pkg::SLOTS;
  localparam int CFG_W      = tsa_pkg::CFG_W;
  localparam int IN_DATA_W  = tsa_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = tsa_pkg::OUT_DATA_W;

  localparam int CLK_HALF    = 4;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 270;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 137;
  localparam int PRINT_MAX   = 40;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [OWNER_W-1:0]  owner;
    logic [TICKET_W-1:0] ticket;
    logic [CODE_W-1:0]   code;
    logic [DELAY_W-1:0]  delay;
    logic                ack;
  } timer_req_t;

  typedef struct packed {
    tsa_pkg::status_t    status;
    logic [TICKET_W-1:0] ticket;
    logic [CODE_W-1:0]   code;
    logic [DELAY_W-1:0]  delay;
    logic [OWNER_W-1:0]  owner;
    logic                notify;
  } timer_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // slot table as the bench sees it
  logic                slot_busy_m  [SLOTS];
  logic [OWNER_W-1:0]  slot_owner_m [SLOTS];
  logic [LEFT_W-1:0]   reuse_left_m [SLOTS];
  logic [HEAP_W-1:0]   heap_m;
  logic [LEFT_W-1:0]   reuse_delay_m;

  timer_res_t expected_q[$];
  int mismatch_cnt   = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;
  int idle_pct       = 0;
  int stall_pct      = 0;
  int holdoff_len    = 0;
  int sent_per_cmd   [4];
  int status_seen    [8];

  always #(CLK_HALF) clk = ~clk;

  timer_slot_allocator_with_reuse_delay_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // table state after reset
  function automatic void clear_slot_table();
    for (int s = 0; s < SLOTS; s++) begin
      slot_busy_m[s]  = 1'b0;
      slot_owner_m[s] = '0;
      reuse_left_m[s] = '0;
    end
    heap_m        = '0;
    reuse_delay_m = 4'd2;
  endfunction

  function automatic void release_slot_m(logic [SLOT_W-1:0] slot);
    slot_busy_m[slot]  = 1'b0;
    reuse_left_m[slot] = reuse_delay_m;
  endfunction

  // expected result of one request, updating the table as the unit would
  function automatic timer_res_t predict_timer_result(timer_req_t r);
    timer_res_t res;
    int s;
    bit got;
    logic [SLOT_W-1:0] slot;
    res = '0;
    res.status = tsa_pkg::ST_NOT_ACTIVE;
    case (r.cmd)
      tsa_pkg::CMD_ALLOC: begin
        // lowest free slot with spent countdown; cooling slots passed count down
        got = 1'b0;
        s = 0;
        while (s < SLOTS && !got) begin
          if (!slot_busy_m[s]) begin
            if (reuse_left_m[s] == '0) begin
              slot_busy_m[s]  = 1'b1;
              slot_owner_m[s] = r.owner;
              got = 1'b1;
            end else begin
              reuse_left_m[s] = reuse_left_m[s] - 1'b1;
            end
          end
          if (!got) s++;
        end
        if (got) begin
          slot = SLOT_W'(s);
          res.status = tsa_pkg::ST_OK;
          res.ticket = TICKET_W'(s + 1);
          res.code   = {heap_m, slot};
          res.delay  = r.delay;
        end else begin
          res.status = tsa_pkg::ST_FULL;
        end
      end
      tsa_pkg::CMD_CANCEL: begin
        if (r.ticket > SLOTS) begin
          res.status = tsa_pkg::ST_NOT_ACTIVE;
        end else if (r.ticket == '0) begin
          res.status = tsa_pkg::ST_NOT_INIT;
        end else begin
          slot = SLOT_W'(r.ticket - 1'b1);
          if (!slot_busy_m[slot]) begin
            res.status = tsa_pkg::ST_NOT_ACTIVE;
          end else if (slot_owner_m[slot] != r.owner) begin
            res.status = tsa_pkg::ST_NOT_OWNER;
          end else if (!r.ack) begin
            res.status = tsa_pkg::ST_NOT_ACKED;
          end else begin
            release_slot_m(slot);
            res.status = tsa_pkg::ST_OK;
          end
        end
      end
      tsa_pkg::CMD_FIRE: begin
        // heap field cannot reach HEAPS at this code width
        slot = r.code[SLOT_W-1:0];
        if (r.code[CODE_W-1:SLOT_W] != heap_m) begin
          res.status = tsa_pkg::ST_WRONG_HEAP;
        end else begin
          if (slot_busy_m[slot]) begin
            res.status = tsa_pkg::ST_OK;
            res.owner  = slot_owner_m[slot];
            res.notify = 1'b1;
          end else begin
            res.status = tsa_pkg::ST_FIRE_EMPTY;
          end
          release_slot_m(slot);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_busy_slot();
    int busy_list[$];
    for (int s = 0; s < SLOTS; s++)
      if (slot_busy_m[s]) busy_list.push_back(s);
    if (busy_list.size() == 0) return -1;
    return busy_list[$urandom_range(busy_list.size() - 1)];
  endfunction

  // random request of a given command, mostly aimed at live slots
  function automatic timer_req_t random_timer_req(logic [CMD_W-1:0] cmd);
    timer_req_t r;
    int s;
    r.cmd    = cmd;
    r.owner  = OWNER_W'($urandom);
    r.ticket = TICKET_W'($urandom);
    r.code   = CODE_W'($urandom);
    r.delay  = $urandom;
    r.ack    = 1'($urandom);
    case (cmd)
      tsa_pkg::CMD_ALLOC: begin
        case ($urandom_range(9))
          0: r.delay = '0;
          1: r.delay = '1;
          default: ;
        endcase
      end
      tsa_pkg::CMD_CANCEL: begin
        s = pick_busy_slot();
        if (s >= 0 && $urandom_range(9) < 7) begin
          r.ticket = TICKET_W'(s + 1);
          if ($urandom_range(19) != 0) r.owner = slot_owner_m[s];
          r.ack = ($urandom_range(99) < 85);
        end else if ($urandom_range(1) == 0) begin
          r.ticket = TICKET_W'($urandom_range(SLOTS));
        end
      end
      tsa_pkg::CMD_FIRE: begin
        s = pick_busy_slot();
        if (s >= 0 && $urandom_range(3) != 0) r.code = {heap_m, SLOT_W'(s)};
        else if ($urandom_range(1) == 0) r.code = {heap_m, SLOT_W'($urandom)};
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_cnt < PRINT_MAX)
      $display("%0t ns mismatch on result %0d: %s", $time, results_seen, what);
    mismatch_cnt++;
  endtask

  // one request transaction, prediction taken at acceptance
  task automatic send_req(input timer_req_t r, output timer_res_t pred);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {1'b0, r.ack, r.delay, r.code, r.ticket, r.owner};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_timer_result(r);
    expected_q.push_back(pred);
    sent_per_cmd[r.cmd]++;
    @(negedge clk);
  endtask

  task automatic send(input timer_req_t r);
    timer_res_t pred;
    send_req(r, pred);
  endtask

  // sender pauses until every expected result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(tsa_pkg::cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tsa_pkg::CFG_HEAP_INDEX) heap_m = val[HEAP_W-1:0];
    else reuse_delay_m = val[LEFT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [HEAP_W-1:0] heap, logic [LEFT_W-1:0] delay);
    drain_results();
    write_cfg(tsa_pkg::CFG_HEAP_INDEX, CFG_W'(heap));
    write_cfg(tsa_pkg::CFG_REUSE_DELAY, CFG_W'(delay));
  endtask

  // range checks, cooling skip, ownership and acknowledge on a fresh table
  task automatic test_directed();
    timer_req_t r;
    idle_pct  = 0;
    stall_pct = 0;
    // cancel with ticket zero, above the table, and at the top slot while empty
    r = random_timer_req(tsa_pkg::CMD_CANCEL);
    r.ticket = '0;
    send(r);
    r.ticket = TICKET_W'(SLOTS + 1);
    send(r);
    r.ticket = '1;
    send(r);
    r.ticket = TICKET_W'(SLOTS);
    send(r);
    // fire for a foreign heap, then fire on an empty slot which starts cooling
    r = random_timer_req(tsa_pkg::CMD_FIRE);
    r.code = '1;
    send(r);
    r.code = '0;
    send(r);
    r = random_timer_req(CMD_UNKNOWN);
    send(r);
    // allocations step over the cooling slot until its countdown runs out
    r = random_timer_req(tsa_pkg::CMD_ALLOC);
    r.owner = '1;
    r.delay = '1;
    send(r);
    r.owner = '0;
    r.delay = '0;
    send(r);
    r.owner = 16'h5a5a;
    send(r);
    // cancel of slot 1: wrong owner, no acknowledge, then accepted
    r = random_timer_req(tsa_pkg::CMD_CANCEL);
    r.ticket = 9'd2;
    r.owner  = '0;
    r.ack    = 1'b1;
    send(r);
    r.owner = '1;
    r.ack   = 1'b0;
    send(r);
    r.ack = 1'b1;
    send(r);
    send(r);
    // fire on live slots reports their owners
    r = random_timer_req(tsa_pkg::CMD_FIRE);
    r.code = {heap_m, 8'd0};
    send(r);
    r.code = {heap_m, 8'd2};
    send(r);
    drain_results();
  endtask

  // fill every slot, allocate on a full table, corrected upper ticket bound
  task automatic test_table_full();
    timer_req_t r;
    timer_res_t pred;
    int full_cnt;
    set_config('1, '0);
    full_cnt = 0;
    while (full_cnt < 2) begin
      r = random_timer_req(tsa_pkg::CMD_ALLOC);
      send_req(r, pred);
      if (pred.status == tsa_pkg::ST_FULL) full_cnt++;
    end
    // ticket equal to the slot count names the top slot
    r = random_timer_req(tsa_pkg::CMD_CANCEL);
    r.ticket = TICKET_W'(SLOTS);
    r.owner  = slot_owner_m[SLOTS-1];
    r.ack    = 1'b1;
    send(r);
    r = random_timer_req(tsa_pkg::CMD_FIRE);
    r.code = {heap_m, 8'hff};
    send(r);
    r.code = {5'd0, 8'hff};
    send(r);
    // long countdown: freed slots are passed over while the table reads full
    set_config('1, '1);
    r = random_timer_req(tsa_pkg::CMD_FIRE);
    r.code = {heap_m, 8'd10};
    send(r);
    r.code = {heap_m, 8'd20};
    send(r);
    r = random_timer_req(tsa_pkg::CMD_ALLOC);
    send(r);
    send(r);
    send(r);
    drain_results();
  endtask

  // receiver holds off while fires keep coming, so the input side stalls
  task automatic test_backpressure();
    timer_req_t r;
    idle_pct    = 0;
    stall_pct   = 0;
    holdoff_len = HOLD_CYCLES;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_busy_m[s] && $urandom_range(7) != 0) begin
        r = random_timer_req(tsa_pkg::CMD_FIRE);
        r.code = {heap_m, SLOT_W'(s)};
        send(r);
      end
    end
    drain_results();
  endtask

  // mixed traffic, mostly well-formed, under one idling pattern
  task automatic test_random(int idle, int stall, logic [HEAP_W-1:0] heap,
                             logic [LEFT_W-1:0] delay, int n_items);
    timer_req_t r;
    int pick;
    int done_cnt;
    set_config(heap, delay);
    idle_pct  = idle;
    stall_pct = stall;
    done_cnt  = 0;
    while (done_cnt < n_items) begin
      pick = $urandom_range(99);
      if (pick < 38) r = random_timer_req(tsa_pkg::CMD_ALLOC);
      else if (pick < 63) r = random_timer_req(tsa_pkg::CMD_CANCEL);
      else if (pick < 90) r = random_timer_req(tsa_pkg::CMD_FIRE);
      else r = random_timer_req(CMD_UNKNOWN);
      send(r);
      done_cnt++;
    end
    drain_results();
  endtask

  // result receiver with random stalls and commanded hold-off stretches
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_len != 0) begin
        hold_left   = holdoff_len;
        holdoff_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    timer_res_t exp_res;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          exp_res = expected_q.pop_front();
          if (out_tuser !== exp_res.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_tuser, exp_res.status));
          if (out_tdata[8:0] !== exp_res.ticket)
            report_mismatch($sformatf("ticket %0d, expected %0d",
                                      out_tdata[8:0], exp_res.ticket));
          if (out_tdata[21:9] !== exp_res.code)
            report_mismatch($sformatf("alarm code %h, expected %h",
                                      out_tdata[21:9], exp_res.code));
          if (out_tdata[53:22] !== exp_res.delay)
            report_mismatch($sformatf("delay %h, expected %h",
                                      out_tdata[53:22], exp_res.delay));
          if (out_tdata[69:54] !== exp_res.owner)
            report_mismatch($sformatf("owner %h, expected %h",
                                      out_tdata[69:54], exp_res.owner));
          if (out_tdata[70] !== exp_res.notify)
            report_mismatch($sformatf("notify %b, expected %b",
                                      out_tdata[70], exp_res.notify));
        end
        if (!$isunknown(out_tuser)) status_seen[out_tuser]++;
        results_seen++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("timer_slot_allocator_with_reuse_delay_unit_tb: FAIL");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = tsa_pkg::CFG_HEAP_INDEX;
    cfg_data  = '0;
    foreach (sent_per_cmd[i]) sent_per_cmd[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_slot_table();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_table_full();
    test_backpressure();
    test_random(0, 0, HEAP_W'($urandom), 4'd2, PHASE_ITEMS);
    test_random(55, 0, '0, '1, PHASE_ITEMS);
    test_random(0, 55, 5'd17, '0, PHASE_ITEMS);
    test_random(16, 16, HEAP_W'($urandom), LEFT_W'($urandom), PHASE_ITEMS);

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

    $display("requests: %0d allocate, %0d cancel, %0d fire, %0d unknown; %0d results checked",
             sent_per_cmd[tsa_pkg::CMD_ALLOC], sent_per_cmd[tsa_pkg::CMD_CANCEL],
             sent_per_cmd[tsa_pkg::CMD_FIRE], sent_per_cmd[CMD_UNKNOWN], results_seen);
    $display("status mix ok/full/inactive/uninit/owner/unacked/empty/heap: %0d %0d %0d %0d",
             status_seen[tsa_pkg::ST_OK], status_seen[tsa_pkg::ST_FULL],
             status_seen[tsa_pkg::ST_NOT_ACTIVE], status_seen[tsa_pkg::ST_NOT_INIT]);
    $display("  %0d %0d %0d %0d",
             status_seen[tsa_pkg::ST_NOT_OWNER], status_seen[tsa_pkg::ST_NOT_ACKED],
             status_seen[tsa_pkg::ST_FIRE_EMPTY], status_seen[tsa_pkg::ST_WRONG_HEAP]);
    if (mismatch_cnt == 0) begin
      $display("timer_slot_allocator_with_reuse_delay_unit_tb: PASS");
    end else begin
      $display("timer_slot_allocator_with_reuse_delay_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
